FILE: design/erl_pkg.sv
// Shared types, constants and helpers for the edge rigidity loss core.
// No dependencies; used by erl_residual and edge_rigidity_loss_core.
`default_nettype none

package erl_pkg;

  // Fixed field widths
  localparam int MODE_W   = 2;
  localparam int SLOT_W   = 12;
  localparam int VERT_W   = 11;
  localparam int GRAD_W   = 40;
  localparam int LOSS_W   = 47;

  // Defaults for the top-level parameters
  localparam int EDGE_SLOTS_DEF   = 4096;
  localparam int VERTEX_SLOTS_DEF = 2048;
  localparam int COORD_BITS_DEF   = 24;

  localparam logic signed [GRAD_W-1:0] GRAD_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [GRAD_W-1:0] GRAD_MIN = 40'sh80_0000_0000;
  localparam logic [LOSS_W-1:0]        LOSS_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_RECORD = 2'd0,
    MODE_EVAL   = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_SQ,
    ST_RDE,
    ST_UPE,
    ST_OUT
  } state_t;

  // Per-axis datapath strobes
  typedef struct packed {
    logic res_en;
    logic sq_en;
  } axis_ctl_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] x;
    logic signed [GRAD_W-1:0] y;
    logic signed [GRAD_W-1:0] z;
  } grad_vec_t;

  // Saturating accumulate of one axis; neg subtracts.
  function automatic logic signed [GRAD_W-1:0] grad_step(
    logic signed [GRAD_W-1:0] acc,
    logic signed [GRAD_W-1:0] delta,
    logic                     neg
  );
    logic signed [GRAD_W:0] sum;
    if (neg) begin
      sum = (GRAD_W+1)'(acc) - (GRAD_W+1)'(delta);
    end else begin
      sum = (GRAD_W+1)'(acc) + (GRAD_W+1)'(delta);
    end
    if (sum > (GRAD_W+1)'(GRAD_MAX)) begin
      return GRAD_MAX;
    end else if (sum < (GRAD_W+1)'(GRAD_MIN)) begin
      return GRAD_MIN;
    end
    return sum[GRAD_W-1:0];
  endfunction

  function automatic grad_vec_t grad_vec_step(
    grad_vec_t acc,
    grad_vec_t delta,
    logic      neg
  );
    grad_vec_t r;
    r.x = grad_step(acc.x, delta.x, neg);
    r.y = grad_step(acc.y, delta.y, neg);
    r.z = grad_step(acc.z, delta.z, neg);
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/erl_residual.sv
// One axis of the loss datapath: saturated residual, then its square.
// Depends on erl_pkg (axis_ctl_t, LOSS_W, LOSS_MAX).
`default_nettype none

module erl_residual #(
  parameter int COORD_BITS = erl_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  erl_pkg::axis_ctl_t            ctl,
  input  logic signed [COORD_BITS:0]    off,
  input  logic signed [COORD_BITS:0]    ref_off,
  output logic signed [COORD_BITS-1:0]  res,
  output logic [erl_pkg::LOSS_W-1:0]    loss
);

  localparam int DW = COORD_BITS + 2;
  localparam int PW = 2 * COORD_BITS;
  localparam logic signed [DW-1:0] RES_HI = {3'b000, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [DW-1:0] RES_LO = {3'b111, {(COORD_BITS-1){1'b0}}};

  logic signed [DW-1:0]         diff;
  logic signed [COORD_BITS-1:0] res_sat;
  logic [COORD_BITS-1:0]        mag;
  logic [PW-1:0]                sq;
  logic [63:0]                  sq_wide;

  assign diff = DW'(off) - DW'(ref_off);

  always_comb begin
    if (diff > RES_HI) begin
      res_sat = RES_HI[COORD_BITS-1:0];
    end else if (diff < RES_LO) begin
      res_sat = RES_LO[COORD_BITS-1:0];
    end else begin
      res_sat = diff[COORD_BITS-1:0];
    end
  end

  // magnitude; the most negative value maps to 2^(C-1), still C bits
  assign mag     = res[COORD_BITS-1] ? (~res + 1'b1) : res;
  assign sq      = PW'(mag) * PW'(mag);
  assign sq_wide = 64'(sq);

  always_ff @(posedge clk) begin
    if (ctl.res_en) begin
      res <= res_sat;
    end
    if (ctl.sq_en) begin
      loss <= (sq_wide > 64'(erl_pkg::LOSS_MAX)) ? erl_pkg::LOSS_MAX
                                                 : sq_wide[erl_pkg::LOSS_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: design/edge_rigidity_loss_core.sv
// Edge rigidity loss core: top level with reference and gradient memories.
// Depends on erl_pkg and erl_residual.
//
// One beat in, one beat out per item. Record items (mode 0) and ignored items
// (mode 3, or an out-of-range slot) go from accept to the output state;
// read-and-clear items (mode 2) first pass through fetch; evaluate items
// (mode 1) through fetch, square, end read and end update. That path is set
// by the gradient memory: it has a single write port and a registered read,
// and both endpoints are updated one after the other (read start, write
// start, read end, write end), so a start/end pair that names the same vertex
// needs no special handling. The result sits in an output register, so the
// next item is taken while the previous result waits for out_ready. After
// reset the gradient memory is swept to zero, one entry per cycle; in_ready
// stays low during that pass. Reference offsets are not cleared: evaluating
// a slot that was never recorded gives an undefined loss and gradient.
`default_nettype none

module edge_rigidity_loss_core #(
  parameter int EDGE_SLOTS   = erl_pkg::EDGE_SLOTS_DEF,
  parameter int VERTEX_SLOTS = erl_pkg::VERTEX_SLOTS_DEF,
  parameter int COORD_BITS   = erl_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [erl_pkg::MODE_W-1:0]          mode,
  input  logic [erl_pkg::SLOT_W-1:0]          edge_slot,
  input  logic [erl_pkg::VERT_W-1:0]          start_vertex,
  input  logic [erl_pkg::VERT_W-1:0]          end_vertex,
  input  logic signed [COORD_BITS-1:0]        start_x,
  input  logic signed [COORD_BITS-1:0]        start_y,
  input  logic signed [COORD_BITS-1:0]        start_z,
  input  logic signed [COORD_BITS-1:0]        end_x,
  input  logic signed [COORD_BITS-1:0]        end_y,
  input  logic signed [COORD_BITS-1:0]        end_z,
  // output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [erl_pkg::LOSS_W-1:0]          loss_x,
  output logic [erl_pkg::LOSS_W-1:0]          loss_y,
  output logic [erl_pkg::LOSS_W-1:0]          loss_z,
  output logic signed [erl_pkg::GRAD_W-1:0]   grad_x,
  output logic signed [erl_pkg::GRAD_W-1:0]   grad_y,
  output logic signed [erl_pkg::GRAD_W-1:0]   grad_z
);

  localparam int EAW = $clog2(EDGE_SLOTS);
  localparam int VAW = $clog2(VERTEX_SLOTS);
  localparam int OW  = COORD_BITS + 1;          // offset width per axis
  localparam logic [VAW-1:0] CLR_LAST = VAW'(VERTEX_SLOTS - 1);

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  erl_pkg::state_t    state, state_next;
  logic [VAW-1:0]     clr_cnt;
  erl_pkg::axis_ctl_t ctl;
  logic               in_fire;
  logic               out_load;

  // Per-item registers, captured on accept
  erl_pkg::mode_t     mode_q;
  logic [VAW-1:0]     vs_q, ve_q;
  logic               vs_ok_q, ve_ok_q;
  logic               is_eval;
  logic signed [OW-1:0] off_q [3];
  erl_pkg::grad_vec_t gacc;        // start vertex gradient read back
  erl_pkg::grad_vec_t gout;        // gradient to report (mode 2)

  // Decode of the incoming beat
  erl_pkg::mode_t     mode_in;
  logic               slot_ok_in, vs_ok_in, ve_ok_in;
  logic [EAW-1:0]     slot_addr;
  logic [VAW-1:0]     vs_addr_in, ve_addr_in;
  logic signed [OW-1:0] off_in [3];

  assign mode_in    = erl_pkg::mode_t'(mode);
  assign slot_ok_in = 32'(edge_slot) < 32'(EDGE_SLOTS);
  assign vs_ok_in   = 32'(start_vertex) < 32'(VERTEX_SLOTS);
  assign ve_ok_in   = 32'(end_vertex) < 32'(VERTEX_SLOTS);
  assign slot_addr  = EAW'(edge_slot);
  assign vs_addr_in = VAW'(start_vertex);
  assign ve_addr_in = VAW'(end_vertex);

  assign off_in[0] = OW'(end_x) - OW'(start_x);
  assign off_in[1] = OW'(end_y) - OW'(start_y);
  assign off_in[2] = OW'(end_z) - OW'(start_z);

  assign in_fire = in_valid && in_ready;

  // ---------------------------------------------------------------------
  // Reference offset memory: written straight from the input beat in
  // record mode, read at the beat's slot every cycle.
  // ---------------------------------------------------------------------
  logic [3*OW-1:0] ref_mem [EDGE_SLOTS];
  logic [3*OW-1:0] ref_rd;
  logic            ref_we;
  logic signed [OW-1:0] ref_ax [3];

  assign ref_we = in_fire && (mode_in == erl_pkg::MODE_RECORD) && slot_ok_in;

  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem[slot_addr] <= {off_in[0], off_in[1], off_in[2]};
    end
    ref_rd <= ref_mem[slot_addr];
  end

  assign ref_ax[0] = ref_rd[3*OW-1:2*OW];
  assign ref_ax[1] = ref_rd[2*OW-1:OW];
  assign ref_ax[2] = ref_rd[OW-1:0];

  // ---------------------------------------------------------------------
  // Gradient accumulator memory: single write port, one read port.
  // ---------------------------------------------------------------------
  erl_pkg::grad_vec_t grad_mem [VERTEX_SLOTS];
  erl_pkg::grad_vec_t grad_rd, grad_wd;
  logic               grad_we;
  logic [VAW-1:0]     grad_wa, grad_ra;

  // end vertex is read only in its own state, after the start write landed
  assign grad_ra = (state == erl_pkg::ST_RDE) ? ve_q : vs_addr_in;

  always_ff @(posedge clk) begin
    if (grad_we) begin
      grad_mem[grad_wa] <= grad_wd;
    end
    grad_rd <= grad_mem[grad_ra];
  end

  // ---------------------------------------------------------------------
  // Per-axis residual and square
  // ---------------------------------------------------------------------
  logic signed [COORD_BITS-1:0]  res  [3];
  logic [erl_pkg::LOSS_W-1:0]    loss [3];
  erl_pkg::grad_vec_t            res_vec;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    erl_residual #(
      .COORD_BITS (COORD_BITS)
    ) u_residual (
      .clk     (clk),
      .ctl     (ctl),
      .off     (off_q[k]),
      .ref_off (ref_ax[k]),
      .res     (res[k]),
      .loss    (loss[k])
    );
  end

  assign res_vec.x = erl_pkg::GRAD_W'(res[0]);
  assign res_vec.y = erl_pkg::GRAD_W'(res[1]);
  assign res_vec.z = erl_pkg::GRAD_W'(res[2]);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= erl_pkg::ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == erl_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    ctl        = '0;
    grad_we    = 1'b0;
    grad_wa    = vs_q;
    grad_wd    = '0;
    case (state)
      erl_pkg::ST_CLEAR: begin
        grad_we = 1'b1;
        grad_wa = clr_cnt;
        if (clr_cnt == CLR_LAST) begin
          state_next = erl_pkg::ST_IDLE;
        end
      end
      erl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if ((mode_in == erl_pkg::MODE_EVAL && slot_ok_in) ||
              mode_in == erl_pkg::MODE_READ) begin
            state_next = erl_pkg::ST_FETCH;
          end else begin
            state_next = erl_pkg::ST_OUT;
          end
        end
      end
      erl_pkg::ST_FETCH: begin
        // reference and start gradient are on the read ports now
        if (mode_q == erl_pkg::MODE_EVAL) begin
          ctl.res_en = 1'b1;
          state_next = erl_pkg::ST_SQ;
        end else begin
          grad_we    = vs_ok_q;          // read and clear
          state_next = erl_pkg::ST_OUT;
        end
      end
      erl_pkg::ST_SQ: begin
        ctl.sq_en  = 1'b1;
        grad_we    = vs_ok_q;
        grad_wd    = erl_pkg::grad_vec_step(gacc, res_vec, 1'b1);
        state_next = erl_pkg::ST_RDE;
      end
      erl_pkg::ST_RDE: begin
        state_next = erl_pkg::ST_UPE;
      end
      erl_pkg::ST_UPE: begin
        grad_we    = ve_ok_q;
        grad_wa    = ve_q;
        grad_wd    = erl_pkg::grad_vec_step(grad_rd, res_vec, 1'b0);
        state_next = erl_pkg::ST_OUT;
      end
      erl_pkg::ST_OUT: begin
        out_load = !out_valid || out_ready;
        if (out_load) begin
          state_next = erl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = erl_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Item registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_q   <= mode_in;
      vs_q     <= vs_addr_in;
      ve_q     <= ve_addr_in;
      vs_ok_q  <= vs_ok_in;
      ve_ok_q  <= ve_ok_in;
      is_eval  <= (mode_in == erl_pkg::MODE_EVAL) && slot_ok_in;
      off_q[0] <= off_in[0];
      off_q[1] <= off_in[1];
      off_q[2] <= off_in[2];
      gout     <= '0;
    end
    if (state == erl_pkg::ST_FETCH) begin
      gacc <= grad_rd;
      if (mode_q == erl_pkg::MODE_READ && vs_ok_q) begin
        gout <= grad_rd;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      loss_x <= is_eval ? loss[0] : '0;
      loss_y <= is_eval ? loss[1] : '0;
      loss_z <= is_eval ? loss[2] : '0;
      grad_x <= gout.x;
      grad_y <= gout.y;
      grad_z <= gout.z;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // one item in flight: the beat after an accept is never accepted at once
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on two consecutive cycles");

  // end vertex update must follow its own read cycle
  a_end_after_read: assert property (@(posedge clk) disable iff (rst)
    state == erl_pkg::ST_UPE |-> $past(state) == erl_pkg::ST_RDE)
    else $error("end vertex update without a fresh read");

  // loss is zero unless the item was an in-range evaluate
  a_loss_zero: assert property (@(posedge clk) disable iff (rst)
    out_load && !is_eval |=> loss_x == '0 && loss_y == '0 && loss_z == '0)
    else $error("nonzero loss on a non-evaluate item");

  // a result appears only out of the output state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == erl_pkg::ST_OUT)
    else $error("result raised outside the output state");

endmodule

`default_nettype wire
